FILE: hw/rtl/dpb_pkg.sv
// Shared constants, widths and register indexes for the depth pixel back-projection block.
// No dependencies; every other file uses it by scoped names.
package dpb_pkg;

   localparam int COORD_BITS      = 12;
   localparam int FOCAL_FRAC_BITS = 24;
   localparam int SUBPIX_BITS     = 4;

   localparam int DEPTH_W = 16;
   localparam int PIXEL_W = 12;
   localparam int OFFS_W  = 17;
   localparam int FOCAL_W = 24;
   localparam int OUT_W   = 24;
   localparam int ADDR_W  = 2;
   localparam int CSR_W   = 24;

   localparam int POS_BASE = (COORD_BITS + SUBPIX_BITS > OFFS_W - 1) ?
                             COORD_BITS + SUBPIX_BITS : OFFS_W - 1;
   localparam int POS_W   = POS_BASE + 2;
   localparam int MAG_W   = POS_W - 1;
   localparam int P1_W    = MAG_W + FOCAL_W;
   localparam int P_W     = P1_W + DEPTH_W;
   localparam int SHIFT   = FOCAL_FRAC_BITS + SUBPIX_BITS;
   localparam int Q_W     = P_W + 1 - SHIFT;
   localparam int CMP_W   = (Q_W > OUT_W + 1) ? Q_W : OUT_W + 1;

   localparam logic [P_W:0]       HALF      = (P_W + 1)'(1) << (SHIFT - 1);
   localparam logic [CMP_W-1:0]   POS_LIMIT = CMP_W'((64'd1 << (OUT_W - 1)) - 64'd1);
   localparam logic [CMP_W-1:0]   NEG_LIMIT = CMP_W'(64'd1 << (OUT_W - 1));
   localparam logic [OUT_W-1:0]   OUT_MAX   = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic [OUT_W-1:0]   OUT_MIN   = {1'b1, {(OUT_W - 1){1'b0}}};

   localparam logic [ADDR_W-1:0] REG_COL_OFFSET = 2'd0;
   localparam logic [ADDR_W-1:0] REG_ROW_OFFSET = 2'd1;
   localparam logic [ADDR_W-1:0] REG_INV_FOCAL  = 2'd2;

   localparam logic signed [OFFS_W-1:0] COL_OFFSET_RST = -17'sd5120;
   localparam logic signed [OFFS_W-1:0] ROW_OFFSET_RST = -17'sd3840;
   localparam logic [FOCAL_W-1:0]       INV_FOCAL_RST  = 24'd32768;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } axis_type;

endpackage

FILE: hw/rtl/dpb_offset.sv
// First stage of one axis: sub-pixel position plus principal offset, split into sign and magnitude.
// Depends on dpb_pkg.
module dpb_offset (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [dpb_pkg::PIXEL_W-1:0]          coord,
   input  logic signed [dpb_pkg::OFFS_W-1:0]    offset,
   output dpb_pkg::axis_type                    axis_ff
);

   logic [dpb_pkg::COORD_BITS-1:0]     coord_w;
   logic signed [dpb_pkg::POS_W-1:0]   pos;
   dpb_pkg::axis_type                  axis_in;

   always_comb begin
      coord_w = dpb_pkg::COORD_BITS'(coord);
      pos = dpb_pkg::POS_W'($signed({1'b0, coord_w, {dpb_pkg::SUBPIX_BITS{1'b0}}}))
            + dpb_pkg::POS_W'(offset);
      axis_in.neg = pos[dpb_pkg::POS_W-1];
      axis_in.mag = axis_in.neg ? dpb_pkg::MAG_W'(-pos) : dpb_pkg::MAG_W'(pos);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axis_ff <= axis_in;
      end
   end

endmodule

FILE: hw/rtl/dpb_mult.sv
// Second and third stages of one axis: magnitude times inverse focal, then times depth.
// Depends on dpb_pkg.
module dpb_mult (
   input  logic                            clock,
   input  logic                            en2,
   input  logic                            en3,
   input  dpb_pkg::axis_type               axis,
   input  logic [dpb_pkg::FOCAL_W-1:0]     inv_focal,
   input  logic [dpb_pkg::DEPTH_W-1:0]     depth,
   output logic                            neg_ff,
   output logic [dpb_pkg::P_W-1:0]         prod_ff
);

   logic                          neg2_ff;
   logic [dpb_pkg::P1_W-1:0]      prod1_ff;
   logic [dpb_pkg::P1_W-1:0]      prod1_in;
   logic [dpb_pkg::P_W-1:0]       prod_in;

   always_comb begin
      prod1_in = dpb_pkg::P1_W'(axis.mag) * dpb_pkg::P1_W'(inv_focal);
      prod_in  = dpb_pkg::P_W'(prod1_ff) * dpb_pkg::P_W'(depth);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         neg2_ff  <= axis.neg;
         prod1_ff <= prod1_in;
      end
      if (en3) begin
         neg_ff  <= neg2_ff;
         prod_ff <= prod_in;
      end
   end

endmodule

FILE: hw/rtl/dpb_round.sv
// Last stage of one axis: round to nearest away from zero, restore sign, saturate, zero if invalid.
// Depends on dpb_pkg.
module dpb_round (
   input  logic                            clock,
   input  logic                            en,
   input  logic                            valid,
   input  logic                            neg,
   input  logic [dpb_pkg::P_W-1:0]         prod,
   output logic [dpb_pkg::OUT_W-1:0]       coord_ff,
   output logic                            sat_ff
);

   logic [dpb_pkg::P_W:0]       sum;
   logic [dpb_pkg::Q_W-1:0]     q;
   logic [dpb_pkg::CMP_W-1:0]   qx;
   logic [dpb_pkg::OUT_W-1:0]   coord_in;
   logic                        sat_in;

   always_comb begin
      sum = (dpb_pkg::P_W + 1)'(prod) + dpb_pkg::HALF;
      q   = dpb_pkg::Q_W'(sum >> dpb_pkg::SHIFT);
      qx  = dpb_pkg::CMP_W'(q);
      coord_in = '0;
      sat_in   = 1'b0;
      if (valid) begin
         if (!neg) begin
            if (qx > dpb_pkg::POS_LIMIT) begin
               coord_in = dpb_pkg::OUT_MAX;
               sat_in   = 1'b1;
            end else begin
               coord_in = dpb_pkg::OUT_W'(qx);
            end
         end else begin
            if (qx > dpb_pkg::NEG_LIMIT) begin
               coord_in = dpb_pkg::OUT_MIN;
               sat_in   = 1'b1;
            end else begin
               coord_in = dpb_pkg::OUT_W'(-qx);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff <= coord_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

FILE: hw/rtl/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection block: registers, handshake and stage control.
// Depends on dpb_pkg, dpb_offset, dpb_mult and dpb_round.
//
// Usage:
//   req_* carries one depth pixel per transaction; rsp_* returns one 3D point per pixel,
//   in order. csr_we/csr_addr/csr_wdata write col_offset (0), row_offset (1) and
//   inv_focal (2); other indexes are ignored. Write them only while the pipe is empty.
//   An accepted request reaches rsp_tvalid through the four register stages (offset add,
//   first multiply, second multiply, round and saturate). Throughput: one pixel per clock
//   while not stalled; each stage takes a new pixel every cycle unless it is held.
//   Each stage holds its contents while the next one is full and stalled, and takes new
//   data as soon as it empties, so a stalled receiver fills the pipe; req_tready drops
//   only when all four stages hold a point.
//   Reset clears all valid bits and loads the register reset values.
//   An invalid depth gives a point with all fields zero and point_valid low.
module depth_pixel_backprojection (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [dpb_pkg::ADDR_W-1:0]        csr_addr,
   input  logic [dpb_pkg::CSR_W-1:0]         csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [39:0]                       req_tdata,  // depth_mm, pixel_col, pixel_row
   input  logic                              req_tuser,  // depth_valid
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,  // point_x, point_y, point_z
   output logic [1:0]                        rsp_tuser   // point_valid, saturated
);

   logic signed [dpb_pkg::OFFS_W-1:0]   col_offset_ff, col_offset_in;
   logic signed [dpb_pkg::OFFS_W-1:0]   row_offset_ff, row_offset_in;
   logic [dpb_pkg::FOCAL_W-1:0]         inv_focal_ff, inv_focal_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;

   logic [dpb_pkg::DEPTH_W-1:0] depth1_ff, depth2_ff, depth3_ff, depth4_ff, depth4_in;
   logic dv1_ff, dv2_ff, dv3_ff, dv4_ff;

   dpb_pkg::axis_type            axis_x, axis_y;
   logic                         neg_x, neg_y;
   logic [dpb_pkg::P_W-1:0]      prod_x, prod_y;
   logic [dpb_pkg::OUT_W-1:0]    point_x, point_y;
   logic                         sat_x, sat_y;

   always_comb begin
      col_offset_in = col_offset_ff;
      row_offset_in = row_offset_ff;
      inv_focal_in  = inv_focal_ff;
      if (csr_we) begin
         case (csr_addr)
            dpb_pkg::REG_COL_OFFSET: col_offset_in = dpb_pkg::OFFS_W'(csr_wdata);
            dpb_pkg::REG_ROW_OFFSET: row_offset_in = dpb_pkg::OFFS_W'(csr_wdata);
            dpb_pkg::REG_INV_FOCAL:  inv_focal_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      adv4 = !v4_ff || rsp_tready;
      adv3 = !v3_ff || adv4;
      adv2 = !v2_ff || adv3;
      adv1 = !v1_ff || adv2;
      v1_in = adv1 ? req_tvalid : v1_ff;
      v2_in = adv2 ? v1_ff : v2_ff;
      v3_in = adv3 ? v2_ff : v3_ff;
      v4_in = adv4 ? v3_ff : v4_ff;
      depth4_in = dv3_ff ? depth3_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_offset_ff <= dpb_pkg::COL_OFFSET_RST;
         row_offset_ff <= dpb_pkg::ROW_OFFSET_RST;
         inv_focal_ff  <= dpb_pkg::INV_FOCAL_RST;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         col_offset_ff <= col_offset_in;
         row_offset_ff <= row_offset_in;
         inv_focal_ff  <= inv_focal_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         depth1_ff <= req_tdata[15:0];
         dv1_ff    <= req_tuser;
      end
      if (adv2) begin
         depth2_ff <= depth1_ff;
         dv2_ff    <= dv1_ff;
      end
      if (adv3) begin
         depth3_ff <= depth2_ff;
         dv3_ff    <= dv2_ff;
      end
      if (adv4) begin
         depth4_ff <= depth4_in;
         dv4_ff    <= dv3_ff;
      end
   end

   dpb_offset u_offset_x (
      .clock   (clock),
      .en      (adv1),
      .coord   (req_tdata[27:16]),
      .offset  (col_offset_ff),
      .axis_ff (axis_x)
   );

   dpb_offset u_offset_y (
      .clock   (clock),
      .en      (adv1),
      .coord   (req_tdata[39:28]),
      .offset  (row_offset_ff),
      .axis_ff (axis_y)
   );

   dpb_mult u_mult_x (
      .clock     (clock),
      .en2       (adv2),
      .en3       (adv3),
      .axis      (axis_x),
      .inv_focal (inv_focal_ff),
      .depth     (depth2_ff),
      .neg_ff    (neg_x),
      .prod_ff   (prod_x)
   );

   dpb_mult u_mult_y (
      .clock     (clock),
      .en2       (adv2),
      .en3       (adv3),
      .axis      (axis_y),
      .inv_focal (inv_focal_ff),
      .depth     (depth2_ff),
      .neg_ff    (neg_y),
      .prod_ff   (prod_y)
   );

   dpb_round u_round_x (
      .clock    (clock),
      .en       (adv4),
      .valid    (dv3_ff),
      .neg      (neg_x),
      .prod     (prod_x),
      .coord_ff (point_x),
      .sat_ff   (sat_x)
   );

   dpb_round u_round_y (
      .clock    (clock),
      .en       (adv4),
      .valid    (dv3_ff),
      .neg      (neg_y),
      .prod     (prod_y),
      .coord_ff (point_y),
      .sat_ff   (sat_y)
   );

   assign req_tready = adv1;
   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {depth4_ff, point_y, point_x};
   assign rsp_tuser  = {sat_x | sat_y, dv4_ff};

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'd0 && !rsp_tuser[1])
      else $error("invalid depth produced a nonzero point");

   a_sat_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("saturation flagged on an invalid point");

   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready)
      else $error("request stalled with a free pipeline stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for depth_pixel_backprojection: streams depth pixels through
// the block under several register settings and checks each 3D point against a predictor.
// Depends on dpb_pkg and the depth_pixel_backprojection RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [dpb_pkg::ADDR_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [15:0] depth;
      logic        valid;
      logic [11:0] col;
      logic [11:0] row;
   } pixel_type;

   typedef struct packed {
      logic [23:0] x;
      logic [23:0] y;
      logic [15:0] z;
      logic        valid;
      logic        sat;
   } point_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [dpb_pkg::ADDR_W-1:0]    csr_addr;
   logic [dpb_pkg::CSR_W-1:0]     csr_wdata;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [39:0]                   req_tdata;
   logic                          req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [63:0]                   rsp_tdata;
   logic [1:0]                    rsp_tuser;

   logic signed [16:0] cfg_col_offset;
   logic signed [16:0] cfg_row_offset;
   logic [23:0]        cfg_inv_focal;

   pixel_type pixel_q[$];
   point_type point_q[$];
   pixel_type req_item;
   logic      req_taken;

   int pixels_queued, pixels_in, points_out, errors;
   int invalid_seen, clipped_seen, settings_seen;
   int req_gap, rsp_gap, idle_odds;
   int long_hold_left;
   bit long_hold_done;

   depth_pixel_backprojection dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic logic [23:0] project_axis(input logic [11:0] coord,
                                                input logic signed [16:0] offs,
                                                input logic [15:0] depth,
                                                output logic clipped);
      longint pos;
      longint unsigned mag, prod, q;
      pos = longint'(coord) * 16 + longint'(offs);
      mag = (pos < 0) ? -pos : pos;
      prod = mag * cfg_inv_focal * depth;
      q = (prod + (64'd1 << (dpb_pkg::SHIFT - 1))) >> dpb_pkg::SHIFT;
      clipped = 1'b0;
      if (pos >= 0) begin
         if (q > 64'd8388607) begin
            clipped = 1'b1;
            return dpb_pkg::OUT_MAX;
         end
         return q[23:0];
      end
      if (q > 64'd8388608) begin
         clipped = 1'b1;
         return dpb_pkg::OUT_MIN;
      end
      return 24'(-q);
   endfunction

   function automatic point_type backproject(input pixel_type px);
      point_type pt;
      logic sx, sy;
      pt = '0;
      if (px.valid) begin
         pt.x = project_axis(px.col, cfg_col_offset, px.depth, sx);
         pt.y = project_axis(px.row, cfg_row_offset, px.depth, sy);
         pt.z = px.depth;
         pt.valid = 1'b1;
         pt.sat = sx | sy;
      end
      return pt;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      case ($urandom_range(0, 7))
         0: px.depth = 16'd0;
         1: px.depth = 16'hFFFF;
         2: px.depth = 16'($urandom_range(0, 255));
         default: px.depth = 16'($urandom);
      endcase
      px.valid = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 5))
         0: px.col = 12'd0;
         1: px.col = 12'hFFF;
         default: px.col = 12'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: px.row = 12'd0;
         1: px.row = 12'hFFF;
         default: px.row = 12'($urandom);
      endcase
      return px;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic queue_pixel(input logic [15:0] depth, input logic valid,
                              input logic [11:0] col, input logic [11:0] row);
      pixel_type px;
      px = '{depth: depth, valid: valid, col: col, row: row};
      pixel_q.insert(pixel_q.size(), px);
      pixels_queued++;
   endtask

   task automatic csr_write(input logic [dpb_pkg::ADDR_W-1:0] addr, input logic [23:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         dpb_pkg::REG_COL_OFFSET: cfg_col_offset = data[16:0];
         dpb_pkg::REG_ROW_OFFSET: cfg_row_offset = data[16:0];
         dpb_pkg::REG_INV_FOCAL:  cfg_inv_focal = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic signed [16:0] col_offs,
                             input logic signed [16:0] row_offs,
                             input logic [23:0] focal);
      logic [6:0] junk_col, junk_row;
      junk_col = 7'($urandom);
      junk_row = 7'($urandom);
      csr_write(dpb_pkg::REG_COL_OFFSET, {junk_col, col_offs});
      csr_write(dpb_pkg::REG_ROW_OFFSET, {junk_row, row_offs});
      csr_write(dpb_pkg::REG_INV_FOCAL, focal);
      csr_write(REG_UNUSED, 24'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
      settings_seen++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pixels_in != pixels_queued || point_q.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      repeat (count) begin
         pixel_q.insert(pixel_q.size(), random_pixel());
         pixels_queued++;
      end
      wait_idle();
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // drive request transactions, with random gaps between them
   always @(negedge clock) begin : drive_req
      pixel_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         req_item <= '0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pixel_q.size() > 0) begin
            nxt = pixel_q.pop_front();
            req_item <= nxt;
            req_tdata <= {nxt.row, nxt.col, nxt.depth};
            req_tuser <= nxt.valid;
            req_tvalid <= 1'b1;
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               req_gap = $urandom_range(1, 13);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // stall the response side in bursts, and once for a long stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!long_hold_done && points_out >= 400) begin
            long_hold_left = 90;
            long_hold_done = 1'b1;
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               rsp_gap = $urandom_range(1, 13);
         end
      end
   end

   always @(posedge clock) begin : watch
      point_type got, want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         want = backproject(req_item);
         point_q.insert(point_q.size(), want);
         pixels_in++;
         if (!want.valid) invalid_seen++;
         if (want.sat) clipped_seen++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x = rsp_tdata[23:0];
         got.y = rsp_tdata[47:24];
         got.z = rsp_tdata[63:48];
         got.valid = rsp_tuser[0];
         got.sat = rsp_tuser[1];
         points_out++;
         if (point_q.size() == 0) begin
            $error("point with no pending pixel: x %0d y %0d z %0d",
                   $signed(got.x), $signed(got.y), got.z);
            errors++;
         end else begin
            want = point_q.pop_front();
            check_field("point_x", longint'($signed(want.x)), longint'($signed(got.x)));
            check_field("point_y", longint'($signed(want.y)), longint'($signed(got.y)));
            check_field("point_z", want.z, got.z);
            check_field("point_valid", want.valid, got.valid);
            check_field("saturated", want.sat, got.sat);
         end
      end
   end

   initial begin
      #5ms;
      $display("FAIL depth_pixel_backprojection");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      idle_odds = 6;
      cfg_col_offset = dpb_pkg::COL_OFFSET_RST;
      cfg_row_offset = dpb_pkg::ROW_OFFSET_RST;
      cfg_inv_focal = dpb_pkg::INV_FOCAL_RST;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset register values: origin, far corners, invalid depth, principal point
      queue_pixel(16'd0, 1'b1, 12'd0, 12'd0);
      queue_pixel(16'hFFFF, 1'b1, 12'hFFF, 12'hFFF);
      queue_pixel(16'hFFFF, 1'b1, 12'd0, 12'd0);
      queue_pixel(16'hFFFF, 1'b0, 12'hFFF, 12'hFFF);
      queue_pixel(16'd0, 1'b0, 12'd0, 12'd0);
      queue_pixel(16'd1000, 1'b1, 12'd320, 12'd240);
      wait_idle();

      // clip high on x and low on y
      set_config(17'sd65535, -17'sd65536, 24'hFFFFFF);
      queue_pixel(16'hFFFF, 1'b1, 12'hFFF, 12'd0);
      queue_pixel(16'd1, 1'b1, 12'd0, 12'hFFF);
      queue_pixel(16'hFFFF, 1'b0, 12'hFFF, 12'd0);
      wait_idle();

      // half-way products round away from zero on both signs
      set_config(17'sd0, -17'sd32, 24'h800000);
      queue_pixel(16'd1, 1'b1, 12'd1, 12'd1);
      queue_pixel(16'd3, 1'b1, 12'd1, 12'd1);
      queue_pixel(16'd1, 1'b1, 12'd0, 12'd0);
      wait_idle();

      // zero reciprocal focal length
      set_config(-17'sd65536, 17'sd65535, 24'd0);
      queue_pixel(16'hFFFF, 1'b1, 12'hFFF, 12'hFFF);
      queue_pixel(16'd12345, 1'b1, 12'd0, 12'd0);
      wait_idle();

      set_config(dpb_pkg::COL_OFFSET_RST, dpb_pkg::ROW_OFFSET_RST, dpb_pkg::INV_FOCAL_RST);
      random_phase(217);
      idle_odds = 0;
      set_config(17'sd65535, -17'sd65536, 24'hFFFFFF);
      random_phase(217);
      idle_odds = 4;
      set_config(-17'sd65536, 17'sd65535, 24'd1);
      random_phase(217);
      repeat (4) begin
         idle_odds = $urandom_range(0, 12);
         set_config(17'($urandom), 17'($urandom),
                    24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23)));
         random_phase(217);
      end
      idle_odds = 0;
      set_config(17'($urandom), 17'($urandom), 24'($urandom_range(1 << 16, 24'hFFFFFF)));
      random_phase(217);

      $display("Back-projected %0d pixels (%0d invalid, %0d clipped) over %0d register settings",
               pixels_in, invalid_seen, clipped_seen, settings_seen);
      $display("Long response stall exercised: %0d, points checked: %0d",
               long_hold_done, points_out);
      if (errors == 0)
         $display("PASS depth_pixel_backprojection");
      else
         $display("FAIL depth_pixel_backprojection");
      $finish;
   end

endmodule
